### rtl/core/ole_pkg.sv
// Package for the ordered list engine: sizes, command codes, cell
// commands and word conversion helpers. No dependencies.
`timescale 1ns / 1ps

package ole_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Fixed transaction field widths
  localparam int unsigned FUNC_W  = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned POSB_W  = 6;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned STAT_W  = 2;

  // Common width for position versus length compares
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT  = 4'd0,
    FN_PUSH_BACK   = 4'd1,
    FN_INSERT      = 4'd2,
    FN_POP_FRONT   = 4'd3,
    FN_POP_BACK    = 4'd4,
    FN_REMOVE_VAL  = 4'd5,
    FN_REMOVE_AT   = 4'd6,
    FN_READ        = 4'd7,
    FN_SWAP        = 4'd8,
    FN_CLEAR       = 4'd9,
    FN_FRONT       = 4'd10,
    FN_BACK        = 4'd11
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    C_HOLD,
    C_MATCH,
    C_INSERT,
    C_REMOVE,
    C_SWAP
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FIND,
    S_READ,
    S_COMMIT
  } ctrl_state_e;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_e op;
    word_t    val;  // insert word or search key
    word_t    wa;   // swap word for the first selected cell
    word_t    wb;   // swap word for the second selected cell
  } cell_cmd_t;

  // Truncate or sign-extend an incoming value to the storage width
  function automatic word_t to_word(logic signed [VALUE_W-1:0] v);
    return DATA_WIDTH'(v);
  endfunction

  // Sign-extend or truncate a stored word to the result width
  function automatic logic [VALUE_W-1:0] word_out(word_t w);
    logic signed [DATA_WIDTH-1:0] s;
    s = w;
    return VALUE_W'(s);
  endfunction

endpackage

### rtl/core/ole_in_if.sv
// Command channel of the ordered list engine.
// Depends on ole_pkg for field widths.
`timescale 1ns / 1ps

interface ole_in_if
  import ole_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;
  logic [POSB_W-1:0]         position_b;

  modport source (output valid, func, value, position, position_b, input ready);
  modport sink   (input valid, func, value, position, position_b, output ready);
endinterface

### rtl/core/ole_out_if.sv
// Result channel of the ordered list engine.
// Depends on ole_pkg for field widths.
`timescale 1ns / 1ps

interface ole_out_if
  import ole_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] data;
  logic                      found;
  logic [STAT_W-1:0]         status;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, data, found, status, count, input ready);
  modport sink   (input valid, data, found, status, count, output ready);
endinterface

### rtl/core/ole_cell.sv
// One storage cell of the list row: holds a word, shifts with its
// neighbors, compares against the search key. Depends on ole_pkg.
`timescale 1ns / 1ps

module ole_cell
  import ole_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_cmd_t cmd_i,
  input  logic      sel_a_i,   // this cell is the first target
  input  logic      sel_b_i,   // this cell is the second target
  input  logic      ge_a_i,    // this cell sits at or after the first target
  input  word_t     left_i,    // word of the lower neighbor
  input  word_t     right_i,   // word of the upper neighbor
  output word_t     word_o,
  output logic      match_o,
  output word_t     rd_a_o,
  output word_t     rd_b_o
);

  word_t word_q, word_d;
  logic  match_q, match_d;

  always_comb begin
    word_d = word_q;
    case (cmd_i.op)
      C_INSERT: begin
        if (sel_a_i) begin
          word_d = cmd_i.val;
        end else if (ge_a_i) begin
          word_d = left_i;
        end
      end
      C_REMOVE: begin
        if (ge_a_i) begin
          word_d = right_i;
        end
      end
      C_SWAP: begin
        if (sel_a_i) begin
          word_d = cmd_i.wa;
        end else if (sel_b_i) begin
          word_d = cmd_i.wb;
        end
      end
      default: word_d = word_q;
    endcase
  end

  assign match_d = (cmd_i.op == C_MATCH) ? (word_q == cmd_i.val) : match_q;

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign word_o  = word_q;
  assign match_o = match_q;
  // Gate onto the read buses; the row ORs them together
  assign rd_a_o  = sel_a_i ? word_q : '0;
  assign rd_b_o  = sel_b_i ? word_q : '0;

endmodule

### rtl/core/ole_ctrl.sv
// Command sequencer of the ordered list engine: takes a transaction,
// steers the cell row and registers the result. Depends on ole_pkg and
// the ole_in_if / ole_out_if interfaces.
`timescale 1ns / 1ps

module ole_ctrl
  import ole_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ole_in_if.sink           req_i,
  ole_out_if.source        rsp_o,
  input  logic [DEPTH-1:0] match_i,
  input  word_t            rd_a_i,
  input  word_t            rd_b_i,
  output cell_cmd_t        cmd_o,
  output logic [DEPTH-1:0] sel_a_o,
  output logic [DEPTH-1:0] sel_b_o,
  output logic [DEPTH-1:0] ge_a_o
);

  ctrl_state_e state_q, state_d;

  logic [FUNC_W-1:0] func_q;
  word_t             val_q;
  logic [POS_W-1:0]  pos_q;
  logic [POSB_W-1:0] posb_q;
  logic [CNT_W-1:0]  len_q, len_d;
  logic [DEPTH-1:0]  sel_a_q, sel_a_d;
  logic [DEPTH-1:0]  sel_b_q, sel_b_d;
  logic              hit_q, hit_d;
  word_t             rd_a_q, rd_b_q;

  logic                 out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]   out_data_q, out_data_d;
  logic                 out_found_q, out_found_d;
  logic [STAT_W-1:0]    out_status_q, out_status_d;

  logic             accept;
  logic             commit_go;
  logic             full, empty, pa_rd_ok, pb_rd_ok, pa_ins_ok, pos_same;
  logic [DEPTH:0]   len_shift;
  logic [DEPTH-1:0] len_mask, hits;
  logic [IDX_W-1:0] pa_idx, last_idx;
  cell_op_e         commit_op;

  function automatic logic [DEPTH-1:0] onehot(logic [IDX_W-1:0] idx);
    return DEPTH'(1) << idx;
  endfunction

  assign accept    = req_i.valid && req_i.ready;
  assign commit_go = (state_q == S_COMMIT) && (!out_valid_q || rsp_o.ready);

  assign full      = (len_q == CNT_W'(DEPTH));
  assign empty     = (len_q == '0);
  assign pa_rd_ok  = CMP_W'(pos_q) < CMP_W'(len_q);
  assign pb_rd_ok  = CMP_W'(posb_q) < CMP_W'(len_q);
  assign pa_ins_ok = CMP_W'(pos_q) <= CMP_W'(len_q);
  assign pos_same  = CMP_W'(pos_q) == CMP_W'(posb_q);
  assign pa_idx    = IDX_W'(pos_q);
  assign last_idx  = IDX_W'(len_q - CNT_W'(1));

  // Cells below the count take part in the search
  assign len_shift = (DEPTH + 1)'(1) << len_q;
  assign len_mask  = DEPTH'(len_shift - (DEPTH + 1)'(1));
  assign hits      = match_i & len_mask;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_EVAL;
      S_EVAL:   state_d = S_FIND;
      S_FIND:   state_d = S_READ;
      S_READ:   state_d = S_COMMIT;
      S_COMMIT: if (commit_go) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Target selection
  always_comb begin
    sel_a_d = sel_a_q;
    sel_b_d = sel_b_q;
    hit_d   = hit_q;
    case (state_q)
      S_EVAL: begin
        sel_b_d = onehot(IDX_W'(posb_q));
        case (func_q)
          FN_PUSH_FRONT, FN_POP_FRONT, FN_FRONT: sel_a_d = onehot('0);
          FN_PUSH_BACK:                          sel_a_d = onehot(IDX_W'(len_q));
          FN_POP_BACK, FN_BACK:                  sel_a_d = onehot(last_idx);
          default:                               sel_a_d = onehot(pa_idx);
        endcase
      end
      S_FIND: begin
        // Isolate the lowest matching cell
        if (func_q == FN_REMOVE_VAL) begin
          sel_a_d = hits & (~hits + DEPTH'(1));
          hit_d   = |hits;
        end else begin
          hit_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Commit decision and result
  always_comb begin
    commit_op    = C_HOLD;
    len_d        = len_q;
    out_data_d   = '0;
    out_found_d  = 1'b0;
    out_status_d = ST_OK;
    case (func_q)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (full) begin
          out_status_d = ST_FULL;
        end else begin
          commit_op = C_INSERT;
          len_d     = len_q + CNT_W'(1);
        end
      end
      FN_INSERT: begin
        if (!pa_ins_ok) begin
          out_status_d = ST_BAD;
        end else if (full) begin
          out_status_d = ST_FULL;
        end else begin
          commit_op = C_INSERT;
          len_d     = len_q + CNT_W'(1);
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (empty) begin
          out_data_d   = '1;
          out_status_d = ST_BAD;
        end else begin
          out_data_d = word_out(rd_a_q);
          commit_op  = C_REMOVE;
          len_d      = len_q - CNT_W'(1);
        end
      end
      FN_REMOVE_VAL: begin
        if (hit_q) begin
          out_data_d  = word_out(rd_a_q);
          out_found_d = 1'b1;
          commit_op   = C_REMOVE;
          len_d       = len_q - CNT_W'(1);
        end
      end
      FN_REMOVE_AT, FN_READ: begin
        if (!pa_rd_ok) begin
          out_data_d   = '1;
          out_status_d = ST_BAD;
        end else begin
          out_data_d = word_out(rd_a_q);
          if (func_q == FN_REMOVE_AT) begin
            commit_op = C_REMOVE;
            len_d     = len_q - CNT_W'(1);
          end
        end
      end
      FN_SWAP: begin
        if (!pos_same) begin
          if (!pa_rd_ok || !pb_rd_ok) begin
            out_status_d = ST_BAD;
          end else begin
            commit_op = C_SWAP;
          end
        end
      end
      FN_CLEAR: len_d = '0;
      FN_FRONT, FN_BACK: begin
        if (empty) begin
          out_data_d   = '1;
          out_status_d = ST_BAD;
        end else begin
          out_data_d = word_out(rd_a_q);
        end
      end
      default: out_status_d = ST_BAD;
    endcase
  end

  // Cell row drive
  always_comb begin
    cmd_o.op  = C_HOLD;
    cmd_o.val = val_q;
    cmd_o.wa  = rd_b_q;
    cmd_o.wb  = rd_a_q;
    case (state_q)
      S_EVAL:   cmd_o.op = C_MATCH;
      S_COMMIT: cmd_o.op = commit_go ? commit_op : C_HOLD;
      default:  cmd_o.op = C_HOLD;
    endcase
  end

  assign sel_a_o = sel_a_q;
  assign sel_b_o = sel_b_q;
  assign ge_a_o  = ~(sel_a_q - DEPTH'(1));

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit_go) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.data    = out_data_q;
  assign rsp_o.found   = out_found_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.count   = COUNT_W'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= commit_go ? len_d : len_q;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      val_q  <= to_word(req_i.value);
      pos_q  <= req_i.position;
      posb_q <= req_i.position_b;
    end
    sel_a_q <= sel_a_d;
    sel_b_q <= sel_b_d;
    if (state_q == S_READ) begin
      rd_a_q <= rd_a_i;
      rd_b_q <= rd_b_i;
    end
    if (commit_go) begin
      out_data_q   <= out_data_d;
      out_found_q  <= out_found_d;
      out_status_q <= out_status_d;
    end
  end

  // The element count never exceeds the row
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(len_q) <= CMP_W'(DEPTH))
    else $error("element count beyond capacity");

  // A taken command starts evaluation on the next cycle
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EVAL)
    else $error("accepted command did not start");

  // Reads see at most one selected cell
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> $onehot0(sel_a_q))
    else $error("more than one target cell");

  // A new result appears only from a commit
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_COMMIT)
    else $error("result without commit");

  // The count moves by at most one, except on clear
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_go && func_q != FN_CLEAR |=>
      (len_q == $past(len_q)) || (len_q == $past(len_q) + CNT_W'(1)) ||
      (len_q == $past(len_q) - CNT_W'(1)))
    else $error("count jumped");

endmodule

### rtl/core/ordered_list_engine.sv
// Top level of the ordered list engine: a row of ole_cell storage cells
// steered by ole_ctrl. Depends on ole_pkg, ole_in_if, ole_out_if.
// A command is taken only while idle; the sequencer walks it through
// evaluate, find, read and commit over the shared cell row, and commit
// waits while rsp_o still holds an untaken result. No new command is taken until then.
// Reset: rst_ni clears the element count and handshake state at once;
// cell contents are undefined until written and need no clearing pass.
`timescale 1ns / 1ps

module ordered_list_engine
  import ole_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ole_in_if.sink    req_i,
  ole_out_if.source rsp_o
);

  cell_cmd_t        cmd;
  logic [DEPTH-1:0] sel_a, sel_b, ge_a;
  logic [DEPTH-1:0] match;
  word_t            words [DEPTH];
  word_t            rd_a  [DEPTH];
  word_t            rd_b  [DEPTH];
  word_t            rd_a_any, rd_b_any;

  // Sequencer: accepts a transaction, walks it through the row and
  // holds the result in an output register while the next one is taken.
  ole_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .match_i (match),
    .rd_a_i  (rd_a_any),
    .rd_b_i  (rd_b_any),
    .cmd_o   (cmd),
    .sel_a_o (sel_a),
    .sel_b_o (sel_b),
    .ge_a_o  (ge_a)
  );

  // Cell row: cell i holds list position i. Insert moves words up by
  // one from the left neighbor, remove pulls them down from the right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = words[i+1];
    end

    ole_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_a_i (sel_a[i]),
      .sel_b_i (sel_b[i]),
      .ge_a_i  (ge_a[i]),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[i]),
      .match_o (match[i]),
      .rd_a_o  (rd_a[i]),
      .rd_b_o  (rd_b[i])
    );
  end

  // Merge the gated read buses; at most one cell drives each
  always_comb begin
    rd_a_any = '0;
    rd_b_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_a_any = rd_a_any | rd_a[i];
      rd_b_any = rd_b_any | rd_b[i];
    end
  end

endmodule
